FILE: hdl/twm_pkg.sv
// Package for the tempo warp map core: item kinds, status codes, state and mode
// enums, and the command and status structs between controller and datapath.
// No dependencies.
`default_nettype none

package twm_pkg;

	localparam logic [1:0] KIND_LOAD = 2'd0;
	localparam logic [1:0] KIND_T2B  = 2'd1;
	localparam logic [1:0] KIND_B2T  = 2'd2;

	localparam logic [1:0] STS_OK      = 2'd0;
	localparam logic [1:0] STS_INVALID = 2'd1;
	localparam logic [1:0] STS_SAT     = 2'd2;

	// Seconds per minute, turns beats per second into bpm
	localparam int BPM_SCALE = 60;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LD_RD,
		ST_LD_CHK,
		ST_LD_DIV,
		ST_Q_RD0,
		ST_Q_CAP0,
		ST_Q_SRD,
		ST_Q_SCMP,
		ST_Q_SEG,
		ST_Q_MUL,
		ST_DONE
	} twm_state_t;

	typedef enum logic [1:0] {
		RD_PREV,
		RD_ZERO,
		RD_NEXT,
		RD_SEG
	} twm_rdsel_t;

	typedef enum logic [1:0] {
		MODE_ERR,
		MODE_LOAD,
		MODE_QUERY
	} twm_mode_t;

	typedef struct packed {
		logic       in_ready;
		logic       capture;
		logic       err;
		logic       mk_rd_en;
		twm_rdsel_t mk_rd_sel;
		logic       ld_chk;
		logic       ld_fin;
		logic       cap0;
		logic       scan_cmp;
		logic       sl_rd_en;
		logic       mul;
		logic       out_load;
	} twm_cmd_t;

	typedef struct packed {
		logic       in_valid;
		logic [1:0] kind;
		logic       invalid;
		logic       slot_bad;
		logic       need_div;
		logic       div_done;
		logic       scan_end;
		logic       out_free;
	} twm_sts_t;

endpackage

`default_nettype wire

FILE: hdl/twm_ifs.sv
// Channel interfaces of the tempo warp map core: item input, result output and
// the marker count write channel. No dependencies.
`default_nettype none

interface twm_item_if;
	logic               valid;
	logic               ready;
	logic [1:0]         kind;
	logic [5:0]         marker_slot;
	logic [31:0]        time_value;
	logic signed [31:0] beat_value;

	modport source (output valid, kind, marker_slot, time_value, beat_value, input ready);
	modport sink   (input valid, kind, marker_slot, time_value, beat_value, output ready);
endinterface

interface twm_result_if;
	logic               valid;
	logic               ready;
	logic signed [32:0] result_value;
	logic [31:0]        tempo_bpm;
	logic [5:0]         segment_used;
	logic [1:0]         status;

	modport source (output valid, result_value, tempo_bpm, segment_used, status,
		input ready);
	modport sink   (input valid, result_value, tempo_bpm, segment_used, status,
		output ready);
endinterface

interface twm_cfg_if;
	logic       valid;
	logic       ready;
	logic [6:0] marker_count;

	modport source (output valid, marker_count, input ready);
	modport sink   (input valid, marker_count, output ready);
endinterface

`default_nettype wire

FILE: hdl/twm_div.sv
// Restoring serial divider for segment slopes: floor((num << FRAC_BITS) / den),
// saturated to 32 bits, one quotient bit per cycle. No dependencies.
`default_nettype none

module twm_div #(
	parameter int FRAC_BITS = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [31:0] num,
	input  wire logic [31:0] den,
	output logic             done,
	output logic [31:0]      quo
);
	localparam int NW = 32 + FRAC_BITS;
	localparam int CW = $clog2(NW + 1);

	logic [NW-1:0] dvd_q;
	logic [NW-1:0] quo_q;
	logic [31:0]   rem_q;
	logic [31:0]   den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [32:0]   trial;
	logic          fits;

	assign trial = {rem_q, dvd_q[NW-1]};
	assign fits  = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CW'(NW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, {FRAC_BITS{1'b0}}};
			den_q <= den;
			rem_q <= '0;
			quo_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[NW-2:0], 1'b0};
			rem_q <= fits ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			quo_q <= {quo_q[NW-2:0], fits};
		end
	end

	assign done = done_q;
	// Saturate when any quotient bit lands above bit 31
	assign quo  = (|quo_q[NW-1:32]) ? '1 : quo_q[31:0];

endmodule

`default_nettype wire

FILE: hdl/twm_ctrl.sv
// Controller of the tempo warp map core: sequences loads and queries over the
// datapath. Depends on twm_pkg.
`default_nettype none

module twm_ctrl (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire twm_pkg::twm_sts_t sts,
	output twm_pkg::twm_cmd_t      cmd
);
	import twm_pkg::*;

	twm_state_t state_q;
	twm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (sts.in_valid) state_d = ST_DECODE;
			end
			ST_DECODE: begin
				case (sts.kind)
					KIND_LOAD: state_d = sts.slot_bad ? ST_DONE : ST_LD_RD;
					KIND_T2B, KIND_B2T: state_d = sts.invalid ? ST_DONE : ST_Q_RD0;
					default: state_d = ST_DONE;
				endcase
			end
			ST_LD_RD:  state_d = ST_LD_CHK;
			ST_LD_CHK: state_d = ST_LD_DIV;
			ST_LD_DIV: begin
				if (!sts.need_div || sts.div_done) state_d = ST_DONE;
			end
			ST_Q_RD0:  state_d = ST_Q_CAP0;
			ST_Q_CAP0: state_d = ST_Q_SRD;
			ST_Q_SRD:  state_d = ST_Q_SCMP;
			ST_Q_SCMP: state_d = sts.scan_end ? ST_Q_SEG : ST_Q_SRD;
			ST_Q_SEG:  state_d = ST_Q_MUL;
			ST_Q_MUL:  state_d = ST_DONE;
			ST_DONE: begin
				if (sts.out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mk_rd_sel = RD_ZERO;
		case (state_q)
			ST_IDLE: begin
				cmd.in_ready = 1'b1;
				cmd.capture  = sts.in_valid;
			end
			ST_DECODE: begin
				case (sts.kind)
					KIND_LOAD: cmd.err = sts.slot_bad;
					KIND_T2B, KIND_B2T: cmd.err = sts.invalid;
					default: cmd.err = 1'b1;
				endcase
			end
			ST_LD_RD: begin
				cmd.mk_rd_en  = 1'b1;
				cmd.mk_rd_sel = RD_PREV;
			end
			ST_LD_CHK: cmd.ld_chk = 1'b1;
			ST_LD_DIV: cmd.ld_fin = !sts.need_div || sts.div_done;
			ST_Q_RD0: begin
				cmd.mk_rd_en  = 1'b1;
				cmd.mk_rd_sel = RD_ZERO;
			end
			ST_Q_CAP0: cmd.cap0 = 1'b1;
			ST_Q_SRD: begin
				cmd.mk_rd_en  = 1'b1;
				cmd.mk_rd_sel = RD_NEXT;
			end
			ST_Q_SCMP: cmd.scan_cmp = 1'b1;
			ST_Q_SEG: begin
				cmd.mk_rd_en  = 1'b1;
				cmd.mk_rd_sel = RD_SEG;
				cmd.sl_rd_en  = 1'b1;
			end
			ST_Q_MUL: cmd.mul = 1'b1;
			ST_DONE:  cmd.out_load = sts.out_free;
			default: cmd = '0;
		endcase
	end

endmodule

`default_nettype wire

FILE: hdl/twm_datapath.sv
// Datapath of the tempo warp map core: item and config registers, marker and
// slope memories, segment scan, multipliers, output register and two slope
// dividers. Depends on twm_pkg, twm_ifs and twm_div.
`default_nettype none

module twm_datapath #(
	parameter int MAX_MARKERS = 64,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	twm_item_if.sink               items,
	twm_result_if.source           results,
	twm_cfg_if.sink                cfg,
	input  wire twm_pkg::twm_cmd_t cmd,
	output twm_pkg::twm_sts_t      sts
);
	import twm_pkg::*;

	localparam int AW = $clog2(MAX_MARKERS);

	logic [1:0]         kind_q;
	logic [5:0]         slot_q;
	logic [31:0]        tv_q;
	logic signed [31:0] bv_q;
	logic [6:0]         cnt_q;
	logic               invalid_q;

	logic [63:0] mk_mem [MAX_MARKERS];
	logic [63:0] sl_mem [MAX_MARKERS];
	logic [63:0] mk_rd_q;
	logic [63:0] sl_rd_q;

	logic [AW-1:0] idx_q;
	logic [AW-1:0] seg_q;
	logic          clamp_q;
	logic          incr_q;
	logic          need_div_q;
	twm_mode_t     mode_q;
	logic [63:0]   prod_q;
	logic [37:0]   bpm_q;

	logic               out_vld_q;
	logic signed [32:0] res_out_q;
	logic [31:0]        bpm_out_q;
	logic [5:0]         seg_out_q;
	logic [1:0]         st_out_q;

	logic [AW-1:0]      slot_addr;
	logic [AW-1:0]      prev_addr;
	logic [AW-1:0]      next_addr;
	logic [AW-1:0]      mk_raddr;
	logic [AW-1:0]      last_w;
	logic [31:0]        cnt_w;
	logic [31:0]        rd_t;
	logic signed [31:0] rd_b;
	logic [32:0]        db_w;
	logic [31:0]        dt_w;
	logic               incr_w;
	logic               hit_w;
	logic               div_go;
	logic [31:0]        d_w;
	logic [31:0]        sl_w;
	logic               done_a;
	logic               done_b;
	logic [31:0]        quo_a;
	logic [31:0]        quo_b;
	logic [63:0]        off_w;
	logic [65:0]        sum_b;
	logic [64:0]        sum_t;
	logic               sat_b;
	logic               sat_bpm;
	logic               sat_t;

	assign slot_addr = AW'(slot_q);
	assign prev_addr = slot_addr - AW'(1);
	assign next_addr = idx_q + AW'(1);
	assign rd_t      = mk_rd_q[63:32];
	assign rd_b      = mk_rd_q[31:0];
	assign cnt_w     = {25'b0, cnt_q};

	// Clamp the marker count into the usable range, then take the last index
	always_comb begin
		if (cnt_w < 32'd2) begin
			last_w = AW'(1);
		end else if (cnt_w > 32'(MAX_MARKERS)) begin
			last_w = AW'(MAX_MARKERS - 1);
		end else begin
			last_w = AW'(cnt_w - 32'd1);
		end
	end

	always_comb begin
		case (cmd.mk_rd_sel)
			RD_PREV: mk_raddr = prev_addr;
			RD_ZERO: mk_raddr = '0;
			RD_NEXT: mk_raddr = next_addr;
			RD_SEG:  mk_raddr = seg_q;
			default: mk_raddr = '0;
		endcase
	end

	// Load check against the marker below
	assign db_w   = {bv_q[31], bv_q} - {rd_b[31], rd_b};
	assign dt_w   = tv_q - rd_t;
	assign incr_w = (tv_q > rd_t) && (bv_q > rd_b);
	assign div_go = cmd.ld_chk && (slot_q != 6'd0) && incr_w;

	assign hit_w = (kind_q == KIND_T2B) ? (tv_q < rd_t) : (bv_q < rd_b);

	assign d_w  = clamp_q ? 32'd0 : ((kind_q == KIND_T2B) ? dt_w : db_w[31:0]);
	assign sl_w = (kind_q == KIND_T2B) ? sl_rd_q[63:32] : sl_rd_q[31:0];

	assign off_w   = prod_q >> FRAC_BITS;
	assign sum_b   = {{34{rd_b[31]}}, rd_b} + {2'b0, off_w};
	assign sum_t   = {33'b0, rd_t} + {1'b0, off_w};
	assign sat_b   = !sum_b[65] && (|sum_b[64:31]);
	assign sat_t   = |sum_t[64:32];
	assign sat_bpm = |bpm_q[37:32];

	always_ff @(posedge clk) begin
		if (cmd.ld_chk) mk_mem[slot_addr] <= {tv_q, bv_q};
		if (cmd.mk_rd_en) mk_rd_q <= mk_mem[mk_raddr];
	end

	always_ff @(posedge clk) begin
		if (cmd.ld_fin && slot_q != 6'd0) begin
			sl_mem[prev_addr] <= incr_q ? {quo_a, quo_b} : 64'd0;
		end
		if (cmd.sl_rd_en) sl_rd_q <= sl_mem[seg_q];
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= items.kind;
			slot_q <= items.marker_slot;
			tv_q   <= items.time_value;
			bv_q   <= items.beat_value;
		end
		if (cmd.ld_chk) incr_q <= incr_w;
		if (cmd.cap0) begin
			clamp_q <= (kind_q == KIND_T2B) ? (tv_q <= rd_t) : (bv_q <= rd_b);
			idx_q   <= '0;
		end
		if (cmd.scan_cmp) begin
			if (sts.scan_end) begin
				seg_q <= clamp_q ? '0 : idx_q;
			end else begin
				idx_q <= next_addr;
			end
		end
		if (cmd.mul) begin
			prod_q <= {32'b0, d_w} * {32'b0, sl_w};
			bpm_q  <= {6'b0, sl_rd_q[63:32]} * 38'(BPM_SCALE);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= 7'd2;
			invalid_q  <= 1'b1;
			need_div_q <= 1'b0;
			mode_q     <= MODE_ERR;
			out_vld_q  <= 1'b0;
		end else begin
			if (cfg.valid) cnt_q <= cfg.marker_count;
			if (cmd.ld_chk) begin
				need_div_q <= div_go;
				if (slot_q == 6'd0) begin
					invalid_q <= 1'b0;
				end else if (!incr_w) begin
					invalid_q <= 1'b1;
				end
			end
			if (cmd.err) mode_q <= MODE_ERR;
			if (cmd.ld_fin) mode_q <= MODE_LOAD;
			if (cmd.mul) mode_q <= MODE_QUERY;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (results.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			res_out_q <= '0;
			bpm_out_q <= '0;
			seg_out_q <= '0;
			case (mode_q)
				MODE_LOAD: st_out_q <= invalid_q ? STS_INVALID : STS_OK;
				MODE_QUERY: begin
					seg_out_q <= 6'(seg_q);
					if (kind_q == KIND_T2B) begin
						res_out_q <= sat_b ? 33'sh07FFFFFFF : {sum_b[31], sum_b[31:0]};
						bpm_out_q <= sat_bpm ? '1 : bpm_q[31:0];
						st_out_q  <= (sat_b || sat_bpm) ? STS_SAT : STS_OK;
					end else begin
						res_out_q <= sat_t ? 33'sh0FFFFFFFF : {1'b0, sum_t[31:0]};
						st_out_q  <= sat_t ? STS_SAT : STS_OK;
					end
				end
				default: st_out_q <= STS_INVALID;
			endcase
		end
	end

	twm_div #(.FRAC_BITS(FRAC_BITS)) u_div_bpt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (db_w[31:0]),
		.den    (dt_w),
		.done   (done_a),
		.quo    (quo_a)
	);

	twm_div #(.FRAC_BITS(FRAC_BITS)) u_div_tpb (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_go),
		.num    (dt_w),
		.den    (db_w[31:0]),
		.done   (done_b),
		.quo    (quo_b)
	);

	assign items.ready = cmd.in_ready;
	assign cfg.ready   = 1'b1;

	assign results.valid        = out_vld_q;
	assign results.result_value = res_out_q;
	assign results.tempo_bpm    = bpm_out_q;
	assign results.segment_used = seg_out_q;
	assign results.status       = st_out_q;

	assign sts.in_valid = items.valid;
	assign sts.kind     = kind_q;
	assign sts.invalid  = invalid_q;
	assign sts.slot_bad = {26'b0, slot_q} >= 32'(MAX_MARKERS);
	assign sts.need_div = need_div_q;
	assign sts.div_done = done_a && done_b;
	assign sts.scan_end = hit_w || (idx_q == last_w - AW'(1));
	assign sts.out_free = !out_vld_q || results.ready;

endmodule

`default_nettype wire

FILE: hdl/tempo_warp_map_core.sv
// Top level of the tempo warp map core: controller plus datapath, channel ports
// and checks. Depends on twm_pkg, twm_ifs, twm_ctrl, twm_datapath and twm_div.
`default_nettype none

// Piecewise-linear tempo map between time (unsigned Q16.16 seconds) and beat
// position (signed Q16.16). Load items write one marker each; slot zero starts a
// new map and clears the invalid flag, a higher slot stores the two slopes of the
// segment ending at it, or marks the map invalid when time or beat does not rise.
// Time-to-beat queries also report bpm (60 times the beat-per-time slope); both
// query kinds clamp below the first marker, extrapolate past the last one, and
// saturate with status 2. One item is processed at a time and the next item is
// taken once the current result sits in the output register, even if that result
// has not yet been picked up. A load that stores slopes waits for the bit-serial
// slope dividers; a load at slot zero or one that does not rise skips the divide.
// A query searches for its segment by walking the markers one at a time through
// the single read port of the marker memory, and stops at the first marker above
// the input or at the last segment. Rejected items go straight to the result.
// A result that waits in a full output register holds the block back. The marker
// count register is written through its own channel, which is always ready, and
// must only be changed while the block is idle.
module tempo_warp_map_core #(
	parameter int MAX_MARKERS = 64,
	parameter int FRAC_BITS   = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	twm_item_if.sink     items,
	twm_result_if.source results,
	twm_cfg_if.sink      cfg
);
	import twm_pkg::*;

	twm_cmd_t cmd;
	twm_sts_t sts;

	// Sequencing: decode, marker read, load check, slope divide, segment scan, multiply
	twm_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.sts    (sts),
		.cmd    (cmd)
	);

	// Storage and arithmetic; owns the channel payloads and the output register
	twm_datapath #(
		.MAX_MARKERS (MAX_MARKERS),
		.FRAC_BITS   (FRAC_BITS)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.items   (items),
		.results (results),
		.cfg     (cfg),
		.cmd     (cmd),
		.sts     (sts)
	);

`ifndef SYNTHESIS
	// Drop ready right after a transfer in: one item in flight at a time
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		items.valid && items.ready |=> !items.ready)
		else $error("item accepted while another is in flight");

	// Never overwrite a result that still waits for its transfer out
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !results.valid || results.ready)
		else $error("result register overwritten");

	// Datapath steps are mutually exclusive
	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.ld_chk, cmd.ld_fin, cmd.cap0, cmd.scan_cmp, cmd.mul,
			cmd.out_load, cmd.capture}))
		else $error("overlapping datapath steps");
`endif

endmodule

`default_nettype wire
